>>> hdl/unique_entry_fifo_queue_defines.svh
// Assertion macros shared by the checker.
`ifndef UNIQUE_ENTRY_FIFO_QUEUE_DEFINES_SVH
`define UNIQUE_ENTRY_FIFO_QUEUE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define UEQ_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication.
`define UEQ_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hdl/ueq_pkg.sv
package ueq_pkg;

	localparam int QUEUE_DEPTH_DEFAULT = 16;
	localparam int VALUE_W = 32;
	localparam int OCC_W = 5;

	localparam logic CMD_PUSH = 1'b0;
	localparam logic CMD_POP  = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_DUP   = 2'd1,
		ST_FULL  = 2'd2,
		ST_EMPTY = 2'd3
	} status_t;

	typedef struct packed {
		logic                      cmd;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	typedef struct packed {
		status_t                   status;
		logic signed [VALUE_W-1:0] popped_value;
		logic [OCC_W-1:0]          occupancy;
	} rsp_t;

endpackage

>>> hdl/ueq_ram.sv
module ueq_ram #(
	parameter int DEPTH = ueq_pkg::QUEUE_DEPTH_DEFAULT,
	parameter int WIDTH = ueq_pkg::VALUE_W,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/ueq_ctrl.sv
module ueq_ctrl #(
	parameter int QUEUE_DEPTH = ueq_pkg::QUEUE_DEPTH_DEFAULT,
	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
	localparam int VW = ueq_pkg::VALUE_W
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            start,
	output logic            busy,
	input  ueq_pkg::req_t   req,
	output logic            done,
	output ueq_pkg::rsp_t   rsp,
	output logic            mem_we,
	output logic [IW-1:0]   mem_waddr,
	output logic [VW-1:0]   mem_wdata,
	output logic            mem_re,
	output logic [IW-1:0]   mem_raddr,
	input  logic [VW-1:0]   mem_rdata
);

	localparam int CW = $clog2(QUEUE_DEPTH + 1);
	localparam int OW = ueq_pkg::OCC_W;
	localparam logic [IW-1:0] LAST_SLOT = IW'(QUEUE_DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(QUEUE_DEPTH);
	localparam logic [CW-1:0] ONE_CNT = CW'(1);

	typedef enum logic [2:0] {
		S_IDLE   = 3'b001,
		S_SEARCH = 3'b010,
		S_POP    = 3'b100
	} state_t;

	state_t state_q, state_d;
	logic [IW-1:0] head_q, head_d, tail_q, tail_d, ptr_q, ptr_d;
	logic [CW-1:0] count_q, count_d, left_q, left_d;
	logic signed [VW-1:0] val_q, val_d;
	logic done_q, done_d;
	ueq_pkg::rsp_t rsp_q, rsp_d;
	logic hit;

	function automatic logic [IW-1:0] next_slot(input logic [IW-1:0] i);
		return (i == LAST_SLOT) ? '0 : i + IW'(1);
	endfunction

	assign hit = (mem_rdata == val_q);

	always_comb begin
		state_d = state_q;
		head_d = head_q;
		tail_d = tail_q;
		count_d = count_q;
		ptr_d = ptr_q;
		left_d = left_q;
		val_d = val_q;
		done_d = 1'b0;
		rsp_d = rsp_q;
		mem_we = 1'b0;
		mem_waddr = tail_q;
		mem_wdata = val_q;
		mem_re = 1'b0;
		mem_raddr = head_q;

		case (state_q)
			S_IDLE: begin
				if (start) begin
					val_d = req.value;
					if (req.cmd == ueq_pkg::CMD_POP) begin
						if (count_q == '0) begin
							done_d = 1'b1;
							rsp_d.status = ueq_pkg::ST_EMPTY;
							rsp_d.popped_value = '0;
							rsp_d.occupancy = OW'(count_q);
						end else begin
							mem_re = 1'b1;
							state_d = S_POP;
						end
					end else if (count_q == '0) begin
						// nothing to search: append at once
						mem_we = 1'b1;
						mem_wdata = req.value;
						tail_d = next_slot(tail_q);
						count_d = ONE_CNT;
						done_d = 1'b1;
						rsp_d.status = ueq_pkg::ST_OK;
						rsp_d.popped_value = '0;
						rsp_d.occupancy = OW'(ONE_CNT);
					end else begin
						mem_re = 1'b1;
						ptr_d = next_slot(head_q);
						left_d = count_q;
						state_d = S_SEARCH;
					end
				end
			end
			S_SEARCH: begin
				// mem_rdata holds the entry read last cycle
				rsp_d.popped_value = '0;
				if (hit) begin
					done_d = 1'b1;
					rsp_d.status = ueq_pkg::ST_DUP;
					rsp_d.occupancy = OW'(count_q);
					state_d = S_IDLE;
				end else if (left_q == ONE_CNT) begin
					done_d = 1'b1;
					state_d = S_IDLE;
					if (count_q == FULL_CNT) begin
						rsp_d.status = ueq_pkg::ST_FULL;
						rsp_d.occupancy = OW'(count_q);
					end else begin
						mem_we = 1'b1;
						tail_d = next_slot(tail_q);
						count_d = count_q + ONE_CNT;
						rsp_d.status = ueq_pkg::ST_OK;
						rsp_d.occupancy = OW'(count_q + ONE_CNT);
					end
				end else begin
					mem_re = 1'b1;
					mem_raddr = ptr_q;
					ptr_d = next_slot(ptr_q);
					left_d = left_q - ONE_CNT;
				end
			end
			S_POP: begin
				head_d = next_slot(head_q);
				count_d = count_q - ONE_CNT;
				done_d = 1'b1;
				rsp_d.status = ueq_pkg::ST_OK;
				rsp_d.popped_value = mem_rdata;
				rsp_d.occupancy = OW'(count_q - ONE_CNT);
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			head_q <= '0;
			tail_q <= '0;
			count_q <= '0;
			done_q <= 1'b0;
		end else begin
			state_q <= state_d;
			head_q <= head_d;
			tail_q <= tail_d;
			count_q <= count_d;
			done_q <= done_d;
		end
	end

	always_ff @(posedge clk) begin
		ptr_q <= ptr_d;
		left_q <= left_d;
		val_q <= val_d;
		rsp_q <= rsp_d;
	end

	assign busy = (state_q != S_IDLE);
	assign done = done_q;
	assign rsp = rsp_q;

endmodule

>>> hdl/unique_entry_fifo_queue.sv
// channel   signals              beat taken when
// command   start, busy, req     start && !busy at a rising edge
// result    done, rsp            done high; one cycle, no backpressure
//
// Pop of a held entry: one memory read, with the result registered from S_POP.
// Push onto held entries: one stored entry compared per cycle through the single
// read port of the entry memory; an append (no match, not full) is written in the
// cycle of the last compare. Empty pop or push: result registered from S_IDLE.
// A new command is taken in the cycle its predecessor's result shows.
// Reset clears head, tail and count; the entry memory is not cleared.
module unique_entry_fifo_queue #(
	parameter int QUEUE_DEPTH = ueq_pkg::QUEUE_DEPTH_DEFAULT
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  ueq_pkg::req_t req,
	output logic          done,
	output ueq_pkg::rsp_t rsp
);

	localparam int IW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int VW = ueq_pkg::VALUE_W;

	logic          mem_we, mem_re;
	logic [IW-1:0] mem_waddr, mem_raddr;
	logic [VW-1:0] mem_wdata, mem_rdata;

	ueq_ctrl #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.req(req),
		.done(done),
		.rsp(rsp),
		.mem_we(mem_we),
		.mem_waddr(mem_waddr),
		.mem_wdata(mem_wdata),
		.mem_re(mem_re),
		.mem_raddr(mem_raddr),
		.mem_rdata(mem_rdata)
	);

	ueq_ram #(.DEPTH(QUEUE_DEPTH), .WIDTH(VW)) u_ram (
		.clk(clk),
		.we(mem_we),
		.waddr(mem_waddr),
		.wdata(mem_wdata),
		.re(mem_re),
		.raddr(mem_raddr),
		.rdata(mem_rdata)
	);

endmodule

>>> hdl/ueq_chk.sv
`include "unique_entry_fifo_queue_defines.svh"

module ueq_chk #(
	parameter int QUEUE_DEPTH = ueq_pkg::QUEUE_DEPTH_DEFAULT
) (
	input logic          clk,
	input logic          arst_n,
	input logic          start,
	input logic          busy,
	input logic          done,
	input ueq_pkg::rsp_t rsp
);

	localparam int OW = ueq_pkg::OCC_W;
	localparam logic [OW-1:0] DEPTH_OCC = OW'(QUEUE_DEPTH);
	localparam logic BIG_DEPTH = (QUEUE_DEPTH > 31);

	// an accepted beat either finishes next cycle or keeps the block busy
	`UEQ_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done, "accepted beat lost")
	// a result beat shows only once the block is free again
	`UEQ_ASSERT_NOW(a_done_idle, done, !busy, "result while busy")
	`UEQ_ASSERT_NOW(a_occ_bound, done, BIG_DEPTH || (rsp.occupancy <= DEPTH_OCC), "occupancy over depth")
	`UEQ_ASSERT_NOW(a_empty_pop, done && (rsp.status == ueq_pkg::ST_EMPTY), (rsp.popped_value == '0) && (rsp.occupancy == '0), "bad empty pop")
	// a full reject only with the queue at depth
	`UEQ_ASSERT_NOW(a_full_rej, done && (rsp.status == ueq_pkg::ST_FULL), BIG_DEPTH || (rsp.occupancy == DEPTH_OCC), "full reject below depth")

endmodule

bind unique_entry_fifo_queue ueq_chk #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_chk (
	.clk(clk),
	.arst_n(arst_n),
	.start(start),
	.busy(busy),
	.done(done),
	.rsp(rsp)
);
